// File: rtl/core/mndt_pkg.sv
package mndt_pkg;

  // Item kinds
  localparam logic KIND_PLAY = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Upper status nibbles
  localparam logic [3:0] NOTE_ON_HI  = 4'h9;
  localparam logic [3:0] NOTE_OFF_HI = 4'h8;

  // One table slot
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [6:0]  rel;
    logic [6:0]  vel;
    logic [6:0]  note;
    logic [3:0]  chan;
  } slot_t;

endpackage

// File: rtl/core/mndt_cell.sv
module mndt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  mndt_pkg::slot_t d,
  output mndt_pkg::slot_t q
);

  // Note info resets to free; times stay unset until written.
  always_ff @(posedge clk) begin
    if (shift) begin
      q.start  <= d.start;
      q.length <= d.length;
    end
    if (rst) begin
      q.rel  <= '0;
      q.vel  <= '0;
      q.note <= '0;
      q.chan <= '0;
    end else if (shift) begin
      q.rel  <= d.rel;
      q.vel  <= d.vel;
      q.note <= d.note;
      q.chan <= d.chan;
    end
  end

endmodule

// File: rtl/core/midi_note_duration_table_core.sv
// Channel   | Handshake         | Beat
// ----------+-------------------+----------------------------------------------
// command   | start, busy       | kind, now_time, channel, note_number,
//           |                   | velocity, duration, release_velocity
// result    | strobe            | status_byte, data_first, data_second, last
//
// Busy stays high for the whole beat: the slot ring rotates once through
// all SLOTS cells (one slot past the head per cycle), then a flush state;
// no new beat is taken until the block is idle again.
// A play beat shows its note-on in the cycle after acceptance. Note-offs of a
// tick come out one found slot late, the final one right after the flush cycle.
// Reset marks every slot free. Results are never stalled by the receiver.
module midi_note_duration_table_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] now_time,
  input  logic [4:0]  channel,
  input  logic [6:0]  note_number,
  input  logic [6:0]  velocity,
  input  logic [31:0] duration,
  input  logic [6:0]  release_velocity,
  output logic        strobe,
  output logic [7:0]  status_byte,
  output logic [6:0]  data_first,
  output logic [6:0]  data_second,
  output logic        last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;
  logic [SW-1:0] step;

  // Latched command
  logic            op;
  logic [31:0]     now_q;
  mndt_pkg::slot_t fresh;
  logic            placed;

  // Held-back note-off so that the final one can carry last
  logic       pend_valid;
  logic [3:0] pend_chan;
  logic [6:0] pend_note;
  logic [6:0] pend_rel;

  // Ring of slot cells; cell 0 is the head, the tail takes the write-back
  mndt_pkg::slot_t ring [SLOTS];
  mndt_pkg::slot_t wb;
  logic            shift;

  assign shift = (state == ST_SCAN);

  genvar k;
  generate
    for (k = 0; k < SLOTS; k++) begin : g_cell
      mndt_pkg::slot_t d_k;
      if (k == SLOTS - 1) begin : g_tail
        assign d_k = wb;
      end else begin : g_link
        assign d_k = ring[k+1];
      end
      mndt_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d    (d_k),
        .q    (ring[k])
      );
    end
  endgenerate

  // Head evaluation
  mndt_pkg::slot_t hd;
  logic [31:0]     age;
  logic            held;
  logic            expired;
  logic            take;
  logic [4:0]      chan_m1;

  assign hd      = ring[0];
  assign held    = (hd.vel != 7'd0);
  assign age     = now_q - hd.start;
  assign expired = (op == mndt_pkg::KIND_TICK) && held && (age > hd.length);
  assign take    = (op == mndt_pkg::KIND_PLAY) && !placed && !held;
  assign chan_m1 = channel - 5'd1;

  always_comb begin
    wb = hd;
    if (take) begin
      wb = fresh;
    end else if (expired) begin
      wb.vel = '0;
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      placed     <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state        <= ST_SCAN;
            step         <= '0;
            placed       <= 1'b0;
            pend_valid   <= 1'b0;
            op           <= kind;
            now_q        <= now_time;
            fresh.start  <= now_time;
            fresh.length <= duration;
            fresh.rel    <= release_velocity;
            fresh.vel    <= velocity;
            fresh.note   <= note_number;
            fresh.chan   <= chan_m1[3:0];
            if (kind == mndt_pkg::KIND_PLAY) begin
              strobe      <= 1'b1;
              last        <= 1'b1;
              status_byte <= {mndt_pkg::NOTE_ON_HI, chan_m1[3:0]};
              data_first  <= note_number;
              data_second <= velocity;
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            placed <= 1'b1;
          end
          if (expired) begin
            if (pend_valid) begin
              strobe      <= 1'b1;
              status_byte <= {mndt_pkg::NOTE_OFF_HI, pend_chan};
              data_first  <= pend_note;
              data_second <= pend_rel;
            end
            pend_valid <= 1'b1;
            pend_chan  <= hd.chan;
            pend_note  <= hd.note;
            pend_rel   <= hd.rel;
          end
          if (step == STEP_LAST) begin
            state <= ST_FLUSH;
          end else begin
            step <= step + SW'(1);
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            strobe      <= 1'b1;
            last        <= 1'b1;
            status_byte <= {mndt_pkg::NOTE_OFF_HI, pend_chan};
            data_first  <= pend_note;
            data_second <= pend_rel;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
